>>> hdl/bpe_pkg.sv
// Shared types and constants for the breakpoint envelope stereo gain core.
`timescale 1ns / 1ps
package bpe_pkg;

  localparam logic [1:0] MODE_LOAD    = 2'd0;
  localparam logic [1:0] MODE_REWIND  = 2'd1;
  localparam logic [1:0] MODE_PROCESS = 2'd2;

  localparam logic [7:0] REG_CLIP_START  = 8'd0;
  localparam logic [7:0] REG_CLIP_LENGTH = 8'd1;
  localparam logic [7:0] REG_BYPASS      = 8'd2;
  localparam logic [7:0] REG_POINT_COUNT = 8'd3;

  localparam logic [16:0] UNITY_GAIN = 17'd65536;
  localparam int unsigned DIV_BITS   = 17;

  typedef struct packed {
    logic take;
    logic rd_seg;
    logic cur_inc;
    logic mul;
    logic div_init;
    logic div_step;
    logic gain_calc;
    logic scale;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic [1:0] mode;
    logic       bypass;
    logic       in_window;
    logic       cur_valid;
    logic       in_seg;
    logic       div_last;
    logic       out_full;
  } sts_t;

endpackage

>>> hdl/bpe_ctrl.sv
// Sequencer for the envelope core: cursor walk, divide and output steps.
`timescale 1ns / 1ps
module bpe_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  bpe_pkg::sts_t sts_i,
  output bpe_pkg::cmd_t cmd_o
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_WALK  = 4'd1;
  localparam logic [3:0] S_CHECK = 4'd2;
  localparam logic [3:0] S_MUL   = 4'd3;
  localparam logic [3:0] S_DINIT = 4'd4;
  localparam logic [3:0] S_DIV   = 4'd5;
  localparam logic [3:0] S_GAIN  = 4'd6;
  localparam logic [3:0] S_SCALE = 4'd7;
  localparam logic [3:0] S_OUT   = 4'd8;

  logic [3:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          if (sts_i.mode == bpe_pkg::MODE_PROCESS) begin
            state_d = (sts_i.bypass || !sts_i.in_window) ? S_SCALE : S_WALK;
          end
        end
      end
      S_WALK: begin
        if (sts_i.cur_valid) begin
          cmd_o.rd_seg = 1'b1;
          state_d      = S_CHECK;
        end else begin
          state_d = S_SCALE;
        end
      end
      S_CHECK: begin
        if (sts_i.in_seg) begin
          state_d = S_MUL;
        end else begin
          cmd_o.cur_inc = 1'b1;
          state_d       = S_WALK;
        end
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = S_DINIT;
      end
      S_DINIT: begin
        cmd_o.div_init = 1'b1;
        state_d        = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) state_d = S_GAIN;
      end
      S_GAIN: begin
        cmd_o.gain_calc = 1'b1;
        state_d         = S_SCALE;
      end
      S_SCALE: begin
        cmd_o.scale = 1'b1;
        state_d     = S_OUT;
      end
      S_OUT: begin
        // hold until the output register frees up
        if (!sts_i.out_full) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

`ifndef SYNTHESIS
  a_load_stays_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.take && sts_i.mode == bpe_pkg::MODE_LOAD |=> state_q == S_IDLE)
    else $error("load word left idle");
  a_div_to_gain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DIV && sts_i.div_last |=> state_q == S_GAIN)
    else $error("divider end missed");
  a_miss_walks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_CHECK && !sts_i.in_seg |=> state_q == S_WALK)
    else $error("segment miss did not advance");
`endif

endmodule

>>> hdl/bpe_dpath.sv
// Datapath: config registers, breakpoint memory, cursor, divider and scaling.
`timescale 1ns / 1ps
module bpe_dpath #(
  parameter int MAX_POINTS = 64
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [7:0]    cfg_index_i,
  input  logic [31:0]   cfg_data_i,
  input  logic [1:0]    in_mode_i,
  input  logic [135:0]  in_data_i,
  input  bpe_pkg::cmd_t cmd_i,
  output bpe_pkg::sts_t sts_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [71:0]   out_data_o
);

  localparam int AW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam int EW = (CW > 7) ? CW : 7;
  localparam int IW = (AW > 6) ? AW : 6;
  localparam int DIV_BITS_W = bpe_pkg::DIV_BITS;

  logic [31:0] clip_start_q, clip_length_q;
  logic        bypass_q;
  logic [6:0]  point_count_q;

  logic [5:0]  in_idx;
  logic [31:0] in_x, in_pos;
  logic [16:0] in_gain, in_gain_sat;
  logic [23:0] in_left, in_right;
  assign in_idx   = in_data_i[5:0];
  assign in_x     = in_data_i[37:6];
  assign in_gain  = in_data_i[54:38];
  assign in_pos   = in_data_i[86:55];
  assign in_left  = in_data_i[110:87];
  assign in_right = in_data_i[134:111];
  assign in_gain_sat = (in_gain > bpe_pkg::UNITY_GAIN) ? bpe_pkg::UNITY_GAIN : in_gain;

  logic [31:0] in_rel;
  assign in_rel = in_pos - clip_start_q;

  // breakpoint memory, one word per point: {position, gain}
  logic [48:0] mem [MAX_POINTS];
  logic [48:0] rd0_q, rd1_q;
  logic [IW-1:0] widx;
  assign widx = IW'(in_idx);

  logic [CW-1:0] cur_q, cur1;
  logic [EW-1:0] cnt_eff;
  assign cur1 = cur_q + CW'(1);
  assign cnt_eff = (EW'(point_count_q) > EW'(MAX_POINTS)) ? EW'(MAX_POINTS)
                                                           : EW'(point_count_q);

  logic [31:0] rel_q;
  logic [23:0] left_q, right_q;
  logic [16:0] g_q;

  logic signed [50:0] prod_q;
  logic [31:0] dx_q;
  logic [16:0] g0_q;
  logic        neg_q;
  logic [31:0] rem_q;
  logic [DIV_BITS_W-1:0] quo_q;
  logic [4:0]  dcnt_q;

  logic signed [41:0] pl_q, pr_q;

  logic [49:0] mag;
  logic [32:0] trial;
  logic        fits;
  logic signed [17:0] dg;
  logic [31:0] drel;
  logic signed [18:0] gsum;

  assign mag   = prod_q[50] ? 50'(-prod_q) : 50'(prod_q);
  assign trial = {rem_q, quo_q[DIV_BITS_W-1]};
  assign fits  = trial >= {1'b0, dx_q};
  assign dg    = $signed({1'b0, rd1_q[16:0]}) - $signed({1'b0, rd0_q[16:0]});
  assign drel  = rel_q - rd0_q[48:17];
  assign gsum  = neg_q ? $signed({2'b00, g0_q}) - $signed({2'b00, quo_q})
                       : $signed({2'b00, g0_q}) + $signed({2'b00, quo_q});

  assign sts_o.mode      = in_mode_i;
  assign sts_o.bypass    = bypass_q;
  assign sts_o.in_window = (in_pos >= clip_start_q) && (in_rel < clip_length_q);
  assign sts_o.cur_valid = EW'(cur_q) < cnt_eff;
  assign sts_o.in_seg    = (EW'(cur1) < cnt_eff) && (rd0_q[48:17] <= rel_q)
                           && (rd1_q[48:17] > rel_q);
  assign sts_o.div_last  = dcnt_q == 5'(bpe_pkg::DIV_BITS - 1);
  assign sts_o.out_full  = out_valid_o && !out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clip_start_q  <= '0;
      clip_length_q <= '0;
      bypass_q      <= 1'b0;
      point_count_q <= 7'd2;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        bpe_pkg::REG_CLIP_START:  clip_start_q  <= cfg_data_i;
        bpe_pkg::REG_CLIP_LENGTH: clip_length_q <= cfg_data_i;
        bpe_pkg::REG_BYPASS:      bypass_q      <= cfg_data_i[0];
        bpe_pkg::REG_POINT_COUNT: point_count_q <= cfg_data_i[6:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take && in_mode_i == bpe_pkg::MODE_LOAD && 32'(widx) < 32'(MAX_POINTS)) begin
      mem[widx[AW-1:0]] <= {in_x, in_gain_sat};
    end
    if (cmd_i.rd_seg) begin
      rd0_q <= mem[cur_q[AW-1:0]];
      rd1_q <= mem[cur1[AW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q <= '0;
    end else if (cmd_i.take && in_mode_i == bpe_pkg::MODE_REWIND) begin
      cur_q <= '0;
    end else if (cmd_i.cur_inc) begin
      cur_q <= cur1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      rel_q   <= in_rel;
      left_q  <= in_left;
      right_q <= in_right;
      g_q     <= bypass_q ? bpe_pkg::UNITY_GAIN : '0;
    end
    if (cmd_i.mul) begin
      prod_q <= dg * $signed({1'b0, drel});
      dx_q   <= rd1_q[48:17] - rd0_q[48:17];
      g0_q   <= rd0_q[16:0];
    end
    if (cmd_i.div_init) begin
      // quotient is below 2^17, so the top bits already sit below the divisor
      rem_q  <= mag[49:17] > 33'(32'hFFFFFFFF) ? '1 : mag[48:17];
      quo_q  <= mag[16:0];
      neg_q  <= prod_q[50];
      dcnt_q <= '0;
    end
    if (cmd_i.div_step) begin
      rem_q  <= fits ? 32'(trial - {1'b0, dx_q}) : trial[31:0];
      quo_q  <= {quo_q[DIV_BITS_W-2:0], fits};
      dcnt_q <= dcnt_q + 5'd1;
    end
    if (cmd_i.gain_calc) begin
      if (gsum < 0) g_q <= '0;
      else if (gsum > $signed({2'b00, bpe_pkg::UNITY_GAIN})) g_q <= bpe_pkg::UNITY_GAIN;
      else g_q <= gsum[16:0];
    end
    if (cmd_i.scale) begin
      pl_q <= $signed(left_q) * $signed({1'b0, g_q});
      pr_q <= $signed(right_q) * $signed({1'b0, g_q});
    end
  end

  logic [71:0] out_q;
  logic        out_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q <= {7'd0, g_q, pr_q[39:16], pl_q[39:16]};
    end
  end

`ifndef SYNTHESIS
  a_gain_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> out_q[64:48] <= bpe_pkg::UNITY_GAIN)
    else $error("gain above unity");
  a_cursor_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.rd_seg |-> EW'(cur_q) < cnt_eff)
    else $error("segment read past count");
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> !(out_valid_q && !out_ready_i))
    else $error("result overwritten");
`endif

endmodule

>>> hdl/breakpoint_envelope_stereo_gain_core.sv
// Top level of the breakpoint envelope stereo gain core.
`timescale 1ns / 1ps
// One word at a time: a load, rewind or unknown-mode word needs no further step;
// a sample in bypass or outside the clip window goes straight to the scale and
// output steps; a sample inside the window walks the cursor with a memory read per
// cursor step, then multiplies, runs the 17-step restoring divider, sets the gain
// and scales, or skips to scaling when the cursor runs past the last point.
// A finished result waits in the output register while the next word is taken;
// a sample that finishes while that register is still full holds until it drains.
module breakpoint_envelope_stereo_gain_core #(
  parameter int MAX_POINTS = 64
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [7:0]   cfg_index_i,
  input  logic [31:0]  cfg_data_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // point_index, point_x, point_gain, sample_position, left_in, right_in
  input  logic [135:0] s_axis_tdata,
  // mode
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // left_out, right_out, gain_used
  output logic [71:0]  m_axis_tdata
);

  bpe_pkg::cmd_t cmd;
  bpe_pkg::sts_t sts;

  assign cfg_ready_o = 1'b1;

  bpe_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  bpe_dpath #(
    .MAX_POINTS (MAX_POINTS)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_mode_i   (s_axis_tuser),
    .in_data_i   (s_axis_tdata),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata)
  );

endmodule

>>> tb/breakpoint_envelope_stereo_gain_core_tb.sv
// Self-checking testbench for the breakpoint envelope stereo gain core.
`timescale 1ns / 1ps
module breakpoint_envelope_stereo_gain_core_tb;

  localparam int NPTS       = 64;
  localparam int LIMIT      = 3000000;
  localparam int DRAIN_WAIT = 200;
  localparam logic [1:0] MODE_UNKNOWN = 2'd3;

  typedef struct packed {
    logic [23:0] left;
    logic [23:0] right;
    logic [16:0] gain;
  } gain_result_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         cfg_valid_i = 1'b0;
  logic         cfg_ready_o;
  logic [7:0]   cfg_index_i = '0;
  logic [31:0]  cfg_data_i = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [135:0] s_axis_tdata = '0;
  logic [1:0]   s_axis_tuser = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [71:0]  m_axis_tdata;

  breakpoint_envelope_stereo_gain_core DUT (.*);

  always #6 clk_i = ~clk_i;

  // predictor state
  logic [31:0] clip_start_q, clip_length_q;
  logic        bypass_q;
  logic [6:0]  point_count_q;
  logic [31:0] pos_tbl [NPTS];
  logic [16:0] gain_tbl [NPTS];
  int          cursor_q;

  gain_result_t expected_q [$];
  int  error_count = 0;
  int  cycle_count = 0;
  bit  idle_en = 1'b1;
  bit  hold_req = 1'b0;
  logic [31:0] ramp_x [NPTS];

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT) begin
      $display("breakpoint_envelope_stereo_gain_core_tb: FAIL");
      $finish;
    end
  end

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    forever begin
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (800) @(posedge clk_i);
        hold_req = 1'b0;
      end else if (idle_en && $urandom_range(0, 3) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
        repeat ($urandom_range(1, 30)) @(posedge clk_i);
      end
    end
  end

  // check each accepted result word against the oldest prediction
  always @(posedge clk_i) begin
    gain_result_t want, got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = '{m_axis_tdata[23:0], m_axis_tdata[47:24], m_axis_tdata[64:48]};
      if (expected_q.size() == 0) begin
        $error("unexpected result word %h", m_axis_tdata);
        error_count++;
      end else begin
        want = expected_q.pop_front();
        if (got.left !== want.left) begin
          $error("left_out expected %h actual %h", want.left, got.left);
          error_count++;
        end
        if (got.right !== want.right) begin
          $error("right_out expected %h actual %h", want.right, got.right);
          error_count++;
        end
        if (got.gain !== want.gain) begin
          $error("gain_used expected %h actual %h", want.gain, got.gain);
          error_count++;
        end
      end
    end
  end

  function automatic logic [23:0] scale_sample(logic signed [23:0] s, logic [16:0] g);
    longint p;
    p = longint'(s) * longint'({15'd0, g});
    return 24'(p >>> 16);
  endfunction

  function automatic logic [16:0] envelope_gain(logic [31:0] rel);
    int cnt;
    longint x0, dx, g0, dg, g;
    cnt = (point_count_q > NPTS) ? NPTS : point_count_q;
    while (cursor_q < cnt) begin
      if (cursor_q + 1 < cnt && pos_tbl[cursor_q] <= rel && pos_tbl[cursor_q + 1] > rel) begin
        x0 = longint'(pos_tbl[cursor_q]);
        dx = longint'(pos_tbl[cursor_q + 1]) - x0;
        g0 = longint'(gain_tbl[cursor_q]);
        dg = longint'(gain_tbl[cursor_q + 1]) - g0;
        g  = g0 + (dg * (longint'(rel) - x0)) / dx;
        if (g < 0) g = 0;
        if (g > 65536) g = 65536;
        return 17'(g);
      end
      cursor_q++;
    end
    return '0;
  endfunction

  task automatic predict_envelope(logic [1:0] mode, logic [135:0] d);
    logic [16:0] g;
    logic [31:0] pos;
    logic [23:0] l, r;
    gain_result_t res;
    l = d[110:87];
    r = d[134:111];
    pos = d[86:55];
    case (mode)
      bpe_pkg::MODE_LOAD: begin
        g = d[54:38];
        gain_tbl[d[5:0]] = (g > bpe_pkg::UNITY_GAIN) ? bpe_pkg::UNITY_GAIN : g;
        pos_tbl[d[5:0]]  = d[37:6];
      end
      bpe_pkg::MODE_REWIND: cursor_q = 0;
      bpe_pkg::MODE_PROCESS: begin
        if (bypass_q) begin
          res = '{l, r, bpe_pkg::UNITY_GAIN};
        end else if ({1'b0, pos} >= {1'b0, clip_start_q} &&
                     {1'b0, pos} < {1'b0, clip_start_q} + {1'b0, clip_length_q}) begin
          g = envelope_gain(pos - clip_start_q);
          res = '{scale_sample(l, g), scale_sample(r, g), g};
        end else begin
          res = '0;
        end
        expected_q.push_back(res);
      end
      default: ;
    endcase
  endtask

  task automatic send_word(logic [1:0] mode, logic [5:0] idx, logic [31:0] x,
                           logic [16:0] g, logic [31:0] pos, logic [23:0] l,
                           logic [23:0] r);
    logic [135:0] d;
    d = {1'b0, r, l, pos, g, x, idx};
    if (idle_en && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= mode;
    s_axis_tdata  <= d;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predict_envelope(mode, d);
  endtask

  task automatic load_point(int idx, logic [31:0] x, logic [16:0] g);
    send_word(bpe_pkg::MODE_LOAD, 6'(idx), x, g, $urandom, 24'($urandom), 24'($urandom));
  endtask

  task automatic sample(logic [31:0] pos, logic [23:0] l, logic [23:0] r);
    send_word(bpe_pkg::MODE_PROCESS, 6'($urandom), $urandom, 17'($urandom), pos, l, r);
  endtask

  task automatic rewind();
    send_word(bpe_pkg::MODE_REWIND, 6'($urandom), $urandom, 17'($urandom), $urandom,
              24'($urandom), 24'($urandom));
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  // write one register once the block has drained
  task automatic cfg_write(logic [7:0] idx, logic [31:0] data);
    wait_idle();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    case (idx)
      bpe_pkg::REG_CLIP_START:  clip_start_q  = data;
      bpe_pkg::REG_CLIP_LENGTH: clip_length_q = data;
      bpe_pkg::REG_BYPASS:      bypass_q      = data[0];
      bpe_pkg::REG_POINT_COUNT: point_count_q = data[6:0];
      default: ;
    endcase
  endtask

  task automatic test_table_fill();
    for (int i = 0; i < NPTS; i++) load_point(i, 32'(i * 100), 17'(i * 1024));
  endtask

  task automatic test_directed();
    cfg_write(bpe_pkg::REG_CLIP_START, 32'd1000);
    cfg_write(bpe_pkg::REG_CLIP_LENGTH, 32'd6300);
    cfg_write(bpe_pkg::REG_POINT_COUNT, 32'd64);
    cfg_write(bpe_pkg::REG_BYPASS, 32'd0);
    load_point(0, 32'd0, 17'd0);
    load_point(1, 32'd100, 17'h1FFFF);       // saturates to unity
    load_point(63, 32'd6300, 17'd65536);
    rewind();
    sample(32'd999, 24'h7FFFFF, 24'h800000); // just before window
    sample(32'd1000, 24'h7FFFFF, 24'h800000);
    sample(32'd1050, 24'h7FFFFF, 24'h800000);
    sample(32'd1100, 24'h800000, 24'h7FFFFF);
    sample(32'd7299, 24'hFFFFFF, 24'h000001); // last frame of window
    sample(32'd7300, 24'h123456, 24'h654321); // just past window
    sample(32'd1050, 24'h7FFFFF, 24'h800000); // cursor does not move back
    send_word(MODE_UNKNOWN, '1, '1, '1, '1, '1, '1);
    rewind();
    sample(32'd1050, 24'h400000, 24'hC00000);
    cfg_write(bpe_pkg::REG_POINT_COUNT, 32'd1);
    rewind();
    sample(32'd1050, 24'h400000, 24'hC00000);
    cfg_write(bpe_pkg::REG_POINT_COUNT, 32'd0);
    sample(32'd1050, 24'h400000, 24'hC00000);
    cfg_write(bpe_pkg::REG_POINT_COUNT, 32'd127);
    rewind();
    sample(32'd1050, 24'h400000, 24'hC00000);
    cfg_write(8'd7, 32'hFFFFFFFF);             // unmapped index
    cfg_write(bpe_pkg::REG_CLIP_START, 32'hFFFFFFF0);
    cfg_write(bpe_pkg::REG_CLIP_LENGTH, 32'hFFFFFFFF);  // window must not wrap
    sample(32'hFFFFFFFF, 24'h7FFFFF, 24'h800000);
    sample(32'd5, 24'h7FFFFF, 24'h800000);
    cfg_write(bpe_pkg::REG_CLIP_LENGTH, 32'd0);
    sample(32'hFFFFFFF0, 24'h7FFFFF, 24'h800000);
    cfg_write(bpe_pkg::REG_BYPASS, 32'd1);
    sample(32'd0, 24'h800000, 24'h7FFFFF);
    cfg_write(bpe_pkg::REG_BYPASS, 32'd0);
  endtask

  // ascending table, rewind, then forward-walking samples among stray words
  task automatic test_envelope_phase(int n_samples);
    int cnt, span;
    logic [31:0] start, xv, rel;
    cnt = $urandom_range(0, 5) == 0 ? 64 : $urandom_range(2, 16);
    span = $urandom_range(1, 400);
    start = ($urandom_range(0, 7) == 0) ? 32'hFFFFFFFF - $urandom_range(0, 20000) : $urandom;
    xv = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 50);
    for (int i = 0; i < cnt; i++) begin
      ramp_x[i] = xv;
      xv = xv + 1 + $urandom_range(0, span);
    end
    cfg_write(bpe_pkg::REG_CLIP_START, start);
    cfg_write(bpe_pkg::REG_CLIP_LENGTH, ramp_x[cnt - 1] + $urandom_range(0, 60));
    cfg_write(bpe_pkg::REG_POINT_COUNT, ($urandom_range(0, 9) == 0) ? 32'd127 : 32'(cnt));
    for (int i = 0; i < cnt; i++) load_point(i, ramp_x[i], 17'($urandom_range(0, 70000)));
    rewind();
    rel = 0;
    for (int k = 0; k < n_samples; k++) begin
      case ($urandom_range(0, 19))
        0: rewind();
        1: send_word(2'($urandom), 6'($urandom), $urandom, 17'($urandom), $urandom,
                     24'($urandom), 24'($urandom));
        2: sample($urandom, 24'($urandom), 24'($urandom));
        3: sample(start - 1, 24'($urandom), 24'($urandom));
        default: begin
          rel = rel + $urandom_range(0, span / 2 + 1);
          sample(start + rel, 24'($urandom), 24'($urandom));
        end
      endcase
    end
  endtask

  task automatic test_bypass_random();
    cfg_write(bpe_pkg::REG_BYPASS, 32'd1);
    for (int k = 0; k < 30; k++) sample($urandom, 24'($urandom), 24'($urandom));
    cfg_write(bpe_pkg::REG_BYPASS, 32'd0);
  endtask

  task automatic test_backpressure();
    cfg_write(bpe_pkg::REG_BYPASS, 32'd1);
    hold_req = 1'b1;
    for (int k = 0; k < 12; k++) sample($urandom, 24'($urandom), 24'($urandom));
    cfg_write(bpe_pkg::REG_BYPASS, 32'd0);
  endtask

  initial begin
    clip_start_q = '0;
    clip_length_q = '0;
    bypass_q = 1'b0;
    point_count_q = 7'd2;
    cursor_q = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_table_fill();
    test_directed();
    test_bypass_random();
    test_backpressure();
    for (int p = 0; p < 8; p++) test_envelope_phase(70);
    idle_en = 1'b0;
    test_envelope_phase(90);
    wait_idle();
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (error_count == 0 && expected_q.size() == 0) begin
      $display("breakpoint_envelope_stereo_gain_core_tb: PASS");
    end else begin
      $display("breakpoint_envelope_stereo_gain_core_tb: FAIL");
    end
    $finish;
  end

endmodule
